@@ src/fcch_pkg.sv @@
// Package for the four-channel coincidence histogram block.
// Holds sizes, register and function codes, payload structs and the sequencer states.
// Used by every module in src; has no dependencies of its own.
package fcch_pkg;

  // Sizes of the rings, the histogram cube and the counters.
  localparam int RING_DEPTH    = 16;
  localparam int MAX_HALF_BINS = 7;
  localparam int COUNT_WIDTH   = 32;

  localparam int SIDE    = 2 * MAX_HALF_BINS + 1;
  localparam int CELLS   = SIDE * SIDE * SIDE;
  localparam int CELL_W  = $clog2(CELLS);
  localparam int RIDX_W  = $clog2(RING_DEPTH);
  localparam int FILL_W  = $clog2(RING_DEPTH + 1);
  localparam int RADDR_W = $clog2(4 * RING_DEPTH);
  localparam int HALF_W  = $clog2(MAX_HALF_BINS + 1);
  localparam int BIN_W   = $clog2(SIDE);

  // Field widths of the ports.
  localparam int TAG_W   = 63;
  localparam int BW_W    = 32;
  localparam int WIN_W   = 40;
  localparam int HB_W    = 3;
  localparam int TAU_W   = 4;
  localparam int ADDED_W = 13;
  localparam int OUT_W   = 32;
  localparam int MUL_W   = BW_W + $clog2(MAX_HALF_BINS + 2);

  localparam logic [ADDED_W-1:0]     ADDED_MAX = '1;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Register bus.
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 64;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_BIN_WIDTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HALF_BINS = 2'd2;

  // Function codes of a command beat.
  localparam logic [1:0] FUNC_EVENT = 2'd0;
  localparam logic [1:0] FUNC_CORR  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  typedef enum logic [1:0] {
    OP_EVENT,
    OP_CORR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [1:0]       func;
    logic [1:0]       channel;
    logic [TAG_W-1:0] tag_time;
    logic [TAU_W-1:0] read_tau1;
    logic [TAU_W-1:0] read_tau2;
    logic [TAU_W-1:0] read_tau3;
  } cmd_t;

  typedef struct packed {
    logic [ADDED_W-1:0] added_count;
    logic [OUT_W-1:0]   total_count;
    logic [OUT_W-1:0]   cell_count;
    logic               ring_overflow;
  } res_t;

  typedef struct packed {
    logic [BW_W-1:0]  bin_width;
    logic [WIN_W-1:0] window_length;
    logic [HB_W-1:0]  half_bins;
  } cfg_t;

  // Classified command as it waits in the queue.
  typedef struct packed {
    op_e              op;
    logic [1:0]       ch;
    logic [2:0][1:0]  oth;
    logic [TAG_W-1:0] tag;
    logic [TAU_W-1:0] tau1;
    logic [TAU_W-1:0] tau2;
    logic [TAU_W-1:0] tau3;
  } job_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic clearing;
    logic pop;
  } bk_stat_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INSERT,
    ST_PRUNE_RD,
    ST_PRUNE_CHK,
    ST_CORR_START,
    ST_FETCH3,
    ST_FETCH2,
    ST_FETCH1,
    ST_WAIT,
    ST_DIFF,
    ST_SUM,
    ST_BIN,
    ST_HRD,
    ST_HWR,
    ST_NEXT,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } bk_state_e;

  // The three channels other than ch, in ascending order (slot 0 first).
  function automatic logic [2:0][1:0] others_of(input logic [1:0] ch);
    logic [2:0][1:0] o;
    case (ch)
      2'd0:    o = {2'd3, 2'd2, 2'd1};
      2'd1:    o = {2'd3, 2'd2, 2'd0};
      2'd2:    o = {2'd3, 2'd1, 2'd0};
      default: o = {2'd2, 2'd1, 2'd0};
    endcase
    return o;
  endfunction

endpackage

@@ src/fcch_regs.sv @@
// Configuration registers of the coincidence histogram behind an APB-style port.
// Depends on fcch_pkg for the register map and the cfg_t struct.
module fcch_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcch_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcch_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcch_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output fcch_pkg::cfg_t                cfg_o
);
  import fcch_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic [REG_IDX_W-1:0] idx;
  logic wr_en;

  assign idx    = paddr[PADDR_W-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_BIN_WIDTH: cfg_d.bin_width     = pwdata[BW_W-1:0];
        REG_WINDOW:    cfg_d.window_length = pwdata[WIN_W-1:0];
        REG_HALF_BINS: cfg_d.half_bins     = pwdata[HB_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bin_width     <= BW_W'(1);
      cfg_q.window_length <= '0;
      cfg_q.half_bins     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read-back mux.
  always_comb begin
    case (idx)
      REG_BIN_WIDTH: prdata = PDATA_W'(cfg_q.bin_width);
      REG_WINDOW:    prdata = PDATA_W'(cfg_q.window_length);
      REG_HALF_BINS: prdata = PDATA_W'(cfg_q.half_bins);
      default:       prdata = '0;
    endcase
  end

endmodule

@@ src/fcch_front.sv @@
// Front end: accepts command beats, classifies them and queues them for the back end.
// Depends on fcch_pkg for cmd_t, job_t, bk_stat_t and the function codes.
module fcch_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  fcch_pkg::cmd_t     cmd_i,
  output logic               busy,
  input  fcch_pkg::bk_stat_t stat_i,
  output logic               job_valid_o,
  output fcch_pkg::job_t     job_o
);
  import fcch_pkg::*;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  job_t              fifo_q [QDEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              full, push, pop;
  job_t              job_new;

  assign full        = (cnt_q == QCNT_W'(QDEPTH));
  assign busy        = full | stat_i.clearing;
  assign push        = start & ~busy;
  assign pop         = stat_i.pop;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = fifo_q[rptr_q];

  // Classify the incoming command.
  always_comb begin
    job_new.ch   = cmd_i.channel;
    job_new.oth  = others_of(cmd_i.channel);
    job_new.tag  = cmd_i.tag_time;
    job_new.tau1 = cmd_i.read_tau1;
    job_new.tau2 = cmd_i.read_tau2;
    job_new.tau3 = cmd_i.read_tau3;
    case (cmd_i.func)
      FUNC_EVENT: job_new.op = OP_EVENT;
      FUNC_CORR:  job_new.op = OP_CORR;
      FUNC_READ:  job_new.op = OP_READ;
      default:    job_new.op = OP_NOP;
    endcase
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wptr_q] <= job_new;
    end
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/fcch_back.sv @@
// Back end: ring insert and prune, the correlation walk, histogram update and read.
// Depends on fcch_pkg; holds the tag ring memory and the histogram memory.
module fcch_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fcch_pkg::cfg_t     cfg_i,
  input  logic               job_valid_i,
  input  fcch_pkg::job_t     job_i,
  output fcch_pkg::bk_stat_t stat_o,
  output logic               result_valid_o,
  output fcch_pkg::res_t     res_o
);
  import fcch_pkg::*;

  bk_state_e state_q, state_d;

  // Ring bookkeeping and loop counters.
  job_t              job_q;
  logic [RIDX_W-1:0] head_q [4];
  logic [FILL_W-1:0] fill_q [4];
  logic [1:0]        pc_q;
  logic [RIDX_W-1:0] m_q, n_q, k_q;
  logic [CELL_W-1:0] clr_q;

  // Tags of the combination under test, indexed by channel.
  logic [TAG_W-1:0]  t_q [4];
  logic              cap_vld_q;
  logic [1:0]        cap_ch_q;
  logic [TAG_W-1:0]  ring_rd_q;

  // Delay lanes for channels 1, 2 and 3 against channel 0.
  logic              neg_q [3];
  logic [TAG_W-1:0]  mag_q [3];
  logic [TAG_W:0]    v_q   [3];
  logic [BIN_W-1:0]  bin_q [3], bin_d [3];
  logic              inr_q, inr_d;
  logic [MUL_W-1:0]  mul_q [1:MAX_HALF_BINS+1];

  logic [CELL_W-1:0]      idx_q;
  logic [COUNT_WIDTH-1:0] hist_rd_q;
  logic [COUNT_WIDTH-1:0] total_q;
  logic [ADDED_W-1:0]     added_q;
  logic [OUT_W-1:0]       cell_q;
  logic                   over_q;
  logic                   rd_hit_q;
  res_t                   res_q;
  logic                   res_vld_q;

  // Memories.
  logic [TAG_W-1:0]       ring_mem [4*RING_DEPTH];
  logic [COUNT_WIDTH-1:0] hist_mem [CELLS];

  // Control from the output decoder.
  logic                   ring_we, ring_re, hist_we, hist_re, pop;
  logic [RADDR_W-1:0]     ring_waddr, ring_raddr;
  logic [CELL_W-1:0]      hist_waddr, hist_raddr;
  logic [COUNT_WIDTH-1:0] hist_wdata;
  logic                   cap_set;
  logic [1:0]             cap_ch;

  // Effective configuration.
  logic [BW_W-1:0]   bw_eff;
  logic [HALF_W-1:0] half_eff;

  // Derived per-job values.
  logic [1:0]        c1, c2, c3;
  logic [FILL_W-1:0] f1, f2, f3;
  logic [RIDX_W-1:0] ins_head;
  logic [FILL_W-1:0] ins_fill;
  logic              ins_over;
  logic              prune_stop;
  logic [TAG_W-1:0]  age;
  logic              any_empty;
  logic [BIN_W:0]    lim;
  logic              rd_ok;
  logic [CELL_W-1:0] rd_idx, cube_idx;

  // Ring address of entry i counted from head h of channel ch.
  function automatic logic [RADDR_W-1:0] raddr(input logic [1:0] ch,
                                               input logic [RIDX_W-1:0] h,
                                               input logic [FILL_W-1:0] i);
    logic [FILL_W:0] s;
    s = (FILL_W+1)'(h) + (FILL_W+1)'(i);
    if (s >= (FILL_W+1)'(RING_DEPTH)) begin
      s = s - (FILL_W+1)'(RING_DEPTH);
    end
    return RADDR_W'(int'(ch) * RING_DEPTH + int'(s));
  endfunction

  function automatic logic [RIDX_W-1:0] ring_inc(input logic [RIDX_W-1:0] h);
    return (h == RIDX_W'(RING_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  function automatic logic [CELL_W-1:0] cell_of(input logic [BIN_W-1:0] b1,
                                                input logic [BIN_W-1:0] b2,
                                                input logic [BIN_W-1:0] b3);
    return CELL_W'(int'(b2) + SIDE * int'(b1) + SIDE * SIDE * int'(b3));
  endfunction

  assign bw_eff   = (cfg_i.bin_width == '0) ? BW_W'(1) : cfg_i.bin_width;
  assign half_eff = (int'(cfg_i.half_bins) > MAX_HALF_BINS) ?
                    HALF_W'(MAX_HALF_BINS) : HALF_W'(cfg_i.half_bins);

  assign c1 = job_q.oth[0];
  assign c2 = job_q.oth[1];
  assign c3 = job_q.oth[2];
  assign f1 = fill_q[c1];
  assign f2 = fill_q[c2];
  assign f3 = fill_q[c3];
  assign any_empty = (f1 == '0) || (f2 == '0) || (f3 == '0);

  // Insert: a full ring drops its oldest tag first.
  always_comb begin
    ins_head = head_q[job_q.ch];
    ins_fill = fill_q[job_q.ch];
    ins_over = 1'b0;
    if (ins_fill >= FILL_W'(RING_DEPTH)) begin
      ins_head = ring_inc(ins_head);
      ins_fill = FILL_W'(RING_DEPTH - 1);
      ins_over = 1'b1;
    end
  end

  // Prune test on the oldest tag of the channel under review.
  assign age        = job_q.tag - ring_rd_q;
  assign prune_stop = (ring_rd_q > job_q.tag) ||
                      (age <= TAG_W'(cfg_i.window_length));

  // Read request: an index outside the active cube reads as zero.
  assign lim    = (BIN_W+1)'({half_eff, 1'b0});
  assign rd_ok  = ((BIN_W+1)'(job_q.tau1) <= lim) && ((BIN_W+1)'(job_q.tau2) <= lim) &&
                  ((BIN_W+1)'(job_q.tau3) <= lim);
  assign rd_idx = cell_of(BIN_W'(job_q.tau1), BIN_W'(job_q.tau2), BIN_W'(job_q.tau3));
  assign cube_idx = cell_of(bin_q[0], bin_q[1], bin_q[2]);

  // Rounded binning: count the multiples of the bin width that the biased
  // magnitude reaches; reaching (half+1) widths puts the delay out of range.
  always_comb begin
    logic [HALF_W:0] q;
    logic            out;
    inr_d = 1'b1;
    for (int l = 0; l < 3; l++) begin
      q   = '0;
      out = 1'b0;
      for (int j = 1; j <= MAX_HALF_BINS + 1; j++) begin
        if (v_q[l] >= (TAG_W+1)'(mul_q[j])) begin
          if (j <= int'(half_eff)) begin
            q = q + 1'b1;
          end
          if (j == int'(half_eff) + 1) begin
            out = 1'b1;
          end
        end
      end
      if (out) begin
        inr_d = 1'b0;
      end
      bin_d[l] = neg_q[l] ? BIN_W'(half_eff) - BIN_W'(q) : BIN_W'(half_eff) + BIN_W'(q);
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (clr_q == CELL_W'(CELLS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (job_valid_i) begin
          case (job_i.op)
            OP_EVENT: state_d = ST_INSERT;
            OP_CORR:  state_d = ST_CORR_START;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_RESULT;
          endcase
        end
      end
      ST_INSERT: state_d = ST_PRUNE_RD;
      ST_PRUNE_RD: begin
        if (fill_q[pc_q] != '0) begin
          state_d = ST_PRUNE_CHK;
        end else if (pc_q == 2'd3) begin
          state_d = ST_CORR_START;
        end
      end
      ST_PRUNE_CHK: begin
        if (prune_stop && pc_q == 2'd3) state_d = ST_CORR_START;
        else                            state_d = ST_PRUNE_RD;
      end
      ST_CORR_START: state_d = any_empty ? ST_RESULT : ST_FETCH3;
      ST_FETCH3:     state_d = ST_FETCH2;
      ST_FETCH2:     state_d = ST_FETCH1;
      ST_FETCH1:     state_d = ST_WAIT;
      ST_WAIT:       state_d = ST_DIFF;
      ST_DIFF:       state_d = ST_SUM;
      ST_SUM:        state_d = ST_BIN;
      ST_BIN:        state_d = ST_HRD;
      ST_HRD:        state_d = inr_q ? ST_HWR : ST_NEXT;
      ST_HWR:        state_d = ST_NEXT;
      ST_NEXT: begin
        if (FILL_W'(k_q) + 1'b1 < f1)      state_d = ST_FETCH1;
        else if (FILL_W'(n_q) + 1'b1 < f2) state_d = ST_FETCH2;
        else if (FILL_W'(m_q) + 1'b1 < f3) state_d = ST_FETCH3;
        else                               state_d = ST_RESULT;
      end
      ST_READ:      state_d = ST_READ_WAIT;
      ST_READ_WAIT: state_d = ST_RESULT;
      ST_RESULT:    state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // Output decode: memory strobes, tag capture and queue pop.
  always_comb begin
    ring_we    = 1'b0;
    ring_waddr = raddr(job_q.ch, ins_head, ins_fill);
    ring_re    = 1'b0;
    ring_raddr = raddr(pc_q, head_q[pc_q], '0);
    hist_we    = 1'b0;
    hist_waddr = idx_q;
    hist_wdata = (hist_rd_q != COUNT_MAX) ? hist_rd_q + 1'b1 : hist_rd_q;
    hist_re    = 1'b0;
    hist_raddr = cube_idx;
    cap_set    = 1'b0;
    cap_ch     = c1;
    pop        = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        hist_waddr = clr_q;
        hist_wdata = '0;
      end
      ST_IDLE:     pop = job_valid_i;
      ST_INSERT:   ring_we = 1'b1;
      ST_PRUNE_RD: ring_re = (fill_q[pc_q] != '0);
      ST_FETCH3: begin
        ring_re    = 1'b1;
        ring_raddr = raddr(c3, head_q[c3], FILL_W'(m_q));
        cap_set    = 1'b1;
        cap_ch     = c3;
      end
      ST_FETCH2: begin
        ring_re    = 1'b1;
        ring_raddr = raddr(c2, head_q[c2], FILL_W'(n_q));
        cap_set    = 1'b1;
        cap_ch     = c2;
      end
      ST_FETCH1: begin
        ring_re    = 1'b1;
        ring_raddr = raddr(c1, head_q[c1], FILL_W'(k_q));
        cap_set    = 1'b1;
        cap_ch     = c1;
      end
      ST_HRD:  hist_re = inr_q;
      ST_HWR:  hist_we = 1'b1;
      ST_READ: begin
        hist_re    = rd_ok;
        hist_raddr = rd_idx;
      end
      default: pop = 1'b0;
    endcase
  end

  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign stat_o.pop      = pop;
  assign result_valid_o  = res_vld_q;
  assign res_o           = res_q;

  // Tag ring memory.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= job_q.tag;
    end
    if (ring_re) begin
      ring_rd_q <= ring_mem[ring_raddr];
    end
  end

  // Histogram memory.
  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
  end

  // Bin width multiples, refreshed every cycle from the register.
  always_ff @(posedge clk_i) begin
    for (int j = 1; j <= MAX_HALF_BINS + 1; j++) begin
      mul_q[j] <= MUL_W'(MUL_W'(bw_eff) * MUL_W'(j));
    end
  end

  // Datapath of the delay lanes and the tag capture.
  always_ff @(posedge clk_i) begin
    if (cap_vld_q) begin
      t_q[cap_ch_q] <= ring_rd_q;
    end
    if (state_q == ST_IDLE && job_valid_i) begin
      job_q <= job_i;
    end
    if (state_q == ST_CORR_START) begin
      t_q[job_q.ch] <= job_q.tag;
    end
    if (state_q == ST_DIFF) begin
      for (int l = 0; l < 3; l++) begin
        neg_q[l] <= t_q[l+1] < t_q[0];
        mag_q[l] <= (t_q[l+1] < t_q[0]) ? t_q[0] - t_q[l+1] : t_q[l+1] - t_q[0];
      end
    end
    if (state_q == ST_SUM) begin
      for (int l = 0; l < 3; l++) begin
        v_q[l] <= (TAG_W+1)'(mag_q[l]) + (TAG_W+1)'(bw_eff >> 1);
      end
    end
    if (state_q == ST_BIN) begin
      bin_q <= bin_d;
      inr_q <= inr_d;
    end
    if (state_q == ST_HRD) begin
      idx_q <= cube_idx;
    end
    if (state_q == ST_READ) begin
      rd_hit_q <= rd_ok;
    end
  end

  // Control state, ring bookkeeping, counters and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      pc_q      <= '0;
      m_q       <= '0;
      n_q       <= '0;
      k_q       <= '0;
      cap_vld_q <= 1'b0;
      cap_ch_q  <= '0;
      total_q   <= '0;
      added_q   <= '0;
      cell_q    <= '0;
      over_q    <= 1'b0;
      res_q     <= '0;
      res_vld_q <= 1'b0;
      for (int c = 0; c < 4; c++) begin
        head_q[c] <= '0;
        fill_q[c] <= '0;
      end
    end else begin
      state_q   <= state_d;
      cap_vld_q <= cap_set;
      cap_ch_q  <= cap_ch;
      res_vld_q <= (state_q == ST_RESULT);
      case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: begin
          added_q <= '0;
          cell_q  <= '0;
          over_q  <= 1'b0;
          pc_q    <= '0;
        end
        ST_INSERT: begin
          head_q[job_q.ch] <= ins_head;
          fill_q[job_q.ch] <= ins_fill + 1'b1;
          over_q           <= ins_over;
        end
        ST_PRUNE_RD: begin
          if (fill_q[pc_q] == '0) pc_q <= pc_q + 1'b1;
        end
        ST_PRUNE_CHK: begin
          if (prune_stop) begin
            pc_q <= pc_q + 1'b1;
          end else begin
            head_q[pc_q] <= ring_inc(head_q[pc_q]);
            fill_q[pc_q] <= fill_q[pc_q] - 1'b1;
          end
        end
        ST_CORR_START: begin
          m_q <= '0;
          n_q <= '0;
          k_q <= '0;
        end
        ST_HWR: begin
          if (total_q != COUNT_MAX) total_q <= total_q + 1'b1;
          if (added_q != ADDED_MAX) added_q <= added_q + 1'b1;
        end
        ST_NEXT: begin
          if (FILL_W'(k_q) + 1'b1 < f1) begin
            k_q <= k_q + 1'b1;
          end else if (FILL_W'(n_q) + 1'b1 < f2) begin
            k_q <= '0;
            n_q <= n_q + 1'b1;
          end else begin
            k_q <= '0;
            n_q <= '0;
            m_q <= m_q + 1'b1;
          end
        end
        ST_READ_WAIT: cell_q <= rd_hit_q ? OUT_W'(hist_rd_q) : '0;
        ST_RESULT: begin
          res_q.added_count   <= added_q;
          res_q.total_count   <= OUT_W'(total_q);
          res_q.cell_count    <= cell_q;
          res_q.ring_overflow <= over_q;
        end
        default: clr_q <= clr_q;
      endcase
    end
  end

endmodule

@@ src/four_channel_coincidence_histogram_top.sv @@
// Top level of the four-channel coincidence histogram.
// Instantiates fcch_regs, fcch_front and fcch_back; depends on fcch_pkg.
//
// Usage: a command beat (cmd_i) is taken at a rising edge with start high and
// busy low. func 0 inserts the tag into its channel ring, prunes every ring
// against the window and correlates; func 1 only correlates; func 2 reads one
// histogram cell; func 3 changes nothing. Each command gives one result beat
// on res_o, marked by result_valid_o for exactly one cycle; the receiver
// cannot stall it. Results come back in command order.
// An event inserts its tag, prunes each ring in turn from its oldest tag,
// reading and checking one tag at a time, and then correlates. A correlation
// that finds an empty ring goes straight to its result; otherwise it walks
// every combination of the other three rings, one at a time through the
// histogram port: fetch the tags, take the delays, add half a bin width, bin
// them, read the cell and, when in range, write it back incremented. With
// full rings of 16 that is 4096 combinations.
// A two-beat queue in front lets the next commands be taken while one works.
// After reset the histogram is cleared one cell a cycle, 3375 cells, with
// busy high. The user must write the registers over the APB port only while
// the block is idle; the block itself does not enforce it.
module four_channel_coincidence_histogram_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  input  fcch_pkg::cmd_t                cmd_i,
  output logic                          busy,
  output logic                          result_valid_o,
  output fcch_pkg::res_t                res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fcch_pkg::PADDR_W-1:0]  paddr,
  input  logic [fcch_pkg::PDATA_W-1:0]  pwdata,
  output logic [fcch_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import fcch_pkg::*;

  cfg_t     cfg;
  bk_stat_t stat;
  logic     job_valid;
  job_t     job;

  // Configuration registers.
  fcch_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Command intake and queue.
  fcch_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .busy        (busy),
    .stat_i      (stat),
    .job_valid_o (job_valid),
    .job_o       (job)
  );

  // Execution of queued commands.
  fcch_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .res_o          (res_o)
  );

endmodule
